### rtl/core/rdpb_pkg.sv
// shared constants, codes and widths for the device pixel bounds block
// no dependencies; used by the channel interfaces and the top level
package rdpb_pkg;

   localparam int COORD_W   = 32;   // Q24.8 user coordinates, Q16.16 gains
   localparam int EDGE_W    = 24;   // pixel edge outputs
   localparam int STATUS_W  = 3;
   localparam int CSR_IDX_W = 3;

   // largest device coordinate in whole pixels
   localparam int COORD_LIMIT = 8388607;

   // device coordinates carry 24 fraction bits after the gain multiply
   localparam int FRAC_Q     = 24;
   // products beyond 2^PROD_BITS are treated as out of range
   localparam int PROD_BITS  = 60;

   localparam logic signed [COORD_W-1:0] GAIN_ONE = 32'sh0001_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_GAIN      = 3'd0,
      CSR_X_TO_Y_GAIN = 3'd1,
      CSR_Y_TO_X_GAIN = 3'd2,
      CSR_Y_GAIN      = 3'd3,
      CSR_OFFSET_X    = 3'd4,
      CSR_OFFSET_Y    = 3'd5
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK           = 3'd0,
      STATUS_EMPTY_EXTENT = 3'd1,
      STATUS_NOT_ALIGNED  = 3'd2,
      STATUS_BAD_BOX      = 3'd3,
      STATUS_EMPTY_PIXELS = 3'd4
   } status_type;

endpackage

### rtl/core/rdpb_req_if.sv
// request channel: one user rectangle per item
// depends on rdpb_pkg for field widths
interface rdpb_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 mode;
   logic signed [rdpb_pkg::COORD_W-1:0]  origin_x;
   logic signed [rdpb_pkg::COORD_W-1:0]  origin_y;
   logic signed [rdpb_pkg::COORD_W-1:0]  extent_w;
   logic signed [rdpb_pkg::COORD_W-1:0]  extent_h;

   modport source (output valid, mode, origin_x, origin_y, extent_w, extent_h, input ready);
   modport sink   (input valid, mode, origin_x, origin_y, extent_w, extent_h, output ready);
endinterface

### rtl/core/rdpb_rsp_if.sv
// response channel: status and device pixel rectangle
// depends on rdpb_pkg for field widths and the status code type
interface rdpb_rsp_if;
   logic                                valid;
   logic                                ready;
   rdpb_pkg::status_type                status;
   logic signed [rdpb_pkg::EDGE_W-1:0]  left;
   logic signed [rdpb_pkg::EDGE_W-1:0]  top;
   logic signed [rdpb_pkg::EDGE_W-1:0]  right;
   logic signed [rdpb_pkg::EDGE_W-1:0]  bottom;

   modport source (output valid, status, left, top, right, bottom, input ready);
   modport sink   (input valid, status, left, top, right, bottom, output ready);
endinterface

### rtl/core/rdpb_csr_if.sv
// configuration write channel: register index and write data
// depends on rdpb_pkg for widths
interface rdpb_csr_if;
   logic                                valid;
   logic                                ready;
   logic [rdpb_pkg::CSR_IDX_W-1:0]      index;
   logic [rdpb_pkg::COORD_W-1:0]        data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/rect_device_pixel_bounds.sv
// pipeline: input register, multiply stage, offset and min/max stage, and rounding stage
// into the result register
// throughput: one item per cycle; a stage holds only while the one after it is full and stalled
// reset: clears all stage valids and loads the identity transform with zero offset
// depends on rdpb_pkg and the rdpb_req_if, rdpb_rsp_if and rdpb_csr_if interfaces
module rect_device_pixel_bounds (
   input  logic       clock,
   input  logic       reset,
   rdpb_req_if.sink   req_bus,
   rdpb_rsp_if.source rsp_bus,
   rdpb_csr_if.sink   csr_bus
);

   localparam int CW   = rdpb_pkg::COORD_W;
   localparam int EW   = rdpb_pkg::EDGE_W;
   localparam int FQ   = rdpb_pkg::FRAC_Q;
   localparam int U_W  = CW + 1;            // normalised user coordinate
   localparam int P_W  = CW + U_W;          // full gain product
   localparam int T_W  = rdpb_pkg::PROD_BITS + 2;  // device coordinate, Q.24
   localparam int R_W  = T_W + 1;           // coordinate plus rounding bias
   localparam int PX_W = R_W - FQ;          // whole-pixel edge

   localparam logic signed [P_W-1:0] PROD_LIM =
      P_W'(64'sd1 <<< rdpb_pkg::PROD_BITS);
   localparam logic signed [T_W-1:0] LIM_Q =
      T_W'(64'(rdpb_pkg::COORD_LIMIT) <<< FQ);
   localparam logic signed [R_W-1:0] BIAS_ZERO = '0;
   localparam logic signed [R_W-1:0] BIAS_HALF = R_W'((64'sd1 <<< (FQ - 1)) - 64'sd1);
   localparam logic signed [R_W-1:0] BIAS_ONE  = R_W'((64'sd1 <<< FQ) - 64'sd1);

   typedef struct packed {
      logic                  mode;
      logic signed [CW-1:0]  x;
      logic signed [CW-1:0]  y;
      logic signed [CW-1:0]  w;
      logic signed [CW-1:0]  h;
   } s1_type;

   typedef struct packed {
      logic                  mode;
      rdpb_pkg::status_type  status;
      logic signed [P_W-1:0] xa;
      logic signed [P_W-1:0] xb;
      logic signed [P_W-1:0] ya;
      logic signed [P_W-1:0] yb;
   } s2_type;

   typedef struct packed {
      logic                  mode;
      rdpb_pkg::status_type  status;
      logic signed [T_W-1:0] x0;
      logic signed [T_W-1:0] x1;
      logic signed [T_W-1:0] y0;
      logic signed [T_W-1:0] y1;
   } s3_type;

   typedef struct packed {
      rdpb_pkg::status_type  status;
      logic signed [EW-1:0]  left;
      logic signed [EW-1:0]  top;
      logic signed [EW-1:0]  right;
      logic signed [EW-1:0]  bottom;
   } res_type;

   // configuration registers
   logic signed [CW-1:0] x_gain_ff, x_to_y_gain_ff, y_to_x_gain_ff, y_gain_ff;
   logic signed [CW-1:0] offset_x_ff, offset_y_ff;

   logic    s1_valid_ff, s2_valid_ff, s3_valid_ff, res_valid_ff;
   s1_type  s1_ff, s1_in;
   s2_type  s2_ff, s2_in;
   s3_type  s3_ff, s3_in;
   res_type res_ff, res_in;

   logic res_free, s3_free, s2_free, s1_free;
   logic csr_write;

   assign res_free = !res_valid_ff || rsp_bus.ready;
   assign s3_free  = !s3_valid_ff || res_free;
   assign s2_free  = !s2_valid_ff || s3_free;
   assign s1_free  = !s1_valid_ff || s2_free;

   assign req_bus.ready = s1_free;
   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid && csr_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_gain_ff      <= rdpb_pkg::GAIN_ONE;
         x_to_y_gain_ff <= '0;
         y_to_x_gain_ff <= '0;
         y_gain_ff      <= rdpb_pkg::GAIN_ONE;
         offset_x_ff    <= '0;
         offset_y_ff    <= '0;
      end else if (csr_write) begin
         case (csr_bus.index)
            rdpb_pkg::CSR_X_GAIN:      x_gain_ff      <= $signed(csr_bus.data);
            rdpb_pkg::CSR_X_TO_Y_GAIN: x_to_y_gain_ff <= $signed(csr_bus.data);
            rdpb_pkg::CSR_Y_TO_X_GAIN: y_to_x_gain_ff <= $signed(csr_bus.data);
            rdpb_pkg::CSR_Y_GAIN:      y_gain_ff      <= $signed(csr_bus.data);
            rdpb_pkg::CSR_OFFSET_X:    offset_x_ff    <= $signed(csr_bus.data);
            rdpb_pkg::CSR_OFFSET_Y:    offset_y_ff    <= $signed(csr_bus.data);
            default: ;
         endcase
      end
   end

   // input register
   always_comb begin
      s1_in.mode = req_bus.mode;
      s1_in.x    = req_bus.origin_x;
      s1_in.y    = req_bus.origin_y;
      s1_in.w    = req_bus.extent_w;
      s1_in.h    = req_bus.extent_h;
   end

   // normalise extents, pick the transform family and multiply
   logic signed [U_W-1:0] ux0, ux1, uy0, uy1, sum_x, sum_y;
   logic signed [U_W-1:0] px0, px1, py0, py1;
   logic signed [CW-1:0]  gx, gy;
   logic                  scale_only, axis_swap;

   always_comb begin
      sum_x = U_W'(s1_ff.x) + U_W'(s1_ff.w);
      sum_y = U_W'(s1_ff.y) + U_W'(s1_ff.h);
      ux0   = s1_ff.w[CW-1] ? sum_x : U_W'(s1_ff.x);
      ux1   = s1_ff.w[CW-1] ? U_W'(s1_ff.x) : sum_x;
      uy0   = s1_ff.h[CW-1] ? sum_y : U_W'(s1_ff.y);
      uy1   = s1_ff.h[CW-1] ? U_W'(s1_ff.y) : sum_y;

      scale_only = (x_to_y_gain_ff == '0) && (y_to_x_gain_ff == '0);
      axis_swap  = (x_gain_ff == '0) && (y_gain_ff == '0);

      // scale-only wins when all four gains are zero
      gx  = scale_only ? x_gain_ff : y_to_x_gain_ff;
      gy  = scale_only ? y_gain_ff : x_to_y_gain_ff;
      px0 = scale_only ? ux0 : uy0;
      px1 = scale_only ? ux1 : uy1;
      py0 = scale_only ? uy0 : ux0;
      py1 = scale_only ? uy1 : ux1;

      s2_in.mode = s1_ff.mode;
      s2_in.xa   = P_W'(gx) * P_W'(px0);
      s2_in.xb   = P_W'(gx) * P_W'(px1);
      s2_in.ya   = P_W'(gy) * P_W'(py0);
      s2_in.yb   = P_W'(gy) * P_W'(py1);

      if ((s1_ff.w == '0) || (s1_ff.h == '0)) begin
         s2_in.status = rdpb_pkg::STATUS_EMPTY_EXTENT;
      end else if (!scale_only && !axis_swap) begin
         s2_in.status = rdpb_pkg::STATUS_NOT_ALIGNED;
      end else begin
         s2_in.status = rdpb_pkg::STATUS_OK;
      end
   end

   // overflow check, add offsets, order the endpoints
   logic signed [T_W-1:0] off_x_q, off_y_q, txa, txb, tya, tyb;
   logic                  prod_ovf;

   always_comb begin
      prod_ovf = (s2_ff.xa > PROD_LIM) || (s2_ff.xa < -PROD_LIM)
              || (s2_ff.xb > PROD_LIM) || (s2_ff.xb < -PROD_LIM)
              || (s2_ff.ya > PROD_LIM) || (s2_ff.ya < -PROD_LIM)
              || (s2_ff.yb > PROD_LIM) || (s2_ff.yb < -PROD_LIM);

      off_x_q = $signed({{(T_W - CW - 16){offset_x_ff[CW-1]}}, offset_x_ff, 16'b0});
      off_y_q = $signed({{(T_W - CW - 16){offset_y_ff[CW-1]}}, offset_y_ff, 16'b0});

      txa = T_W'(s2_ff.xa) + off_x_q;
      txb = T_W'(s2_ff.xb) + off_x_q;
      tya = T_W'(s2_ff.ya) + off_y_q;
      tyb = T_W'(s2_ff.yb) + off_y_q;

      s3_in.mode = s2_ff.mode;
      s3_in.x0   = (txa < txb) ? txa : txb;
      s3_in.x1   = (txa < txb) ? txb : txa;
      s3_in.y0   = (tya < tyb) ? tya : tyb;
      s3_in.y1   = (tya < tyb) ? tyb : tya;

      if ((s2_ff.status == rdpb_pkg::STATUS_OK) && prod_ovf) begin
         s3_in.status = rdpb_pkg::STATUS_BAD_BOX;
      end else begin
         s3_in.status = s2_ff.status;
      end
   end

   // range check and rounding to whole pixels
   logic                   out_of_range;
   logic signed [R_W-1:0]  bias_near, bias_far;
   logic signed [R_W-1:0]  rl, rt, rr, rb;
   logic signed [PX_W-1:0] px_l, px_t, px_r, px_b;

   always_comb begin
      out_of_range = (s3_ff.x0 < -LIM_Q) || (s3_ff.x0 > LIM_Q)
                  || (s3_ff.x1 < -LIM_Q) || (s3_ff.x1 > LIM_Q)
                  || (s3_ff.y0 < -LIM_Q) || (s3_ff.y0 > LIM_Q)
                  || (s3_ff.y1 < -LIM_Q) || (s3_ff.y1 > LIM_Q)
                  || (s3_ff.x1 <= s3_ff.x0) || (s3_ff.y1 <= s3_ff.y0);

      // touched: floor near, ceil far; covered: first pixel centre at or after
      bias_near = s3_ff.mode ? BIAS_ZERO : BIAS_HALF;
      bias_far  = s3_ff.mode ? BIAS_ONE  : BIAS_HALF;

      rl = R_W'(s3_ff.x0) + bias_near;
      rt = R_W'(s3_ff.y0) + bias_near;
      rr = R_W'(s3_ff.x1) + bias_far;
      rb = R_W'(s3_ff.y1) + bias_far;

      px_l = $signed(rl[R_W-1:FQ]);
      px_t = $signed(rt[R_W-1:FQ]);
      px_r = $signed(rr[R_W-1:FQ]);
      px_b = $signed(rb[R_W-1:FQ]);

      res_in.left   = '0;
      res_in.top    = '0;
      res_in.right  = '0;
      res_in.bottom = '0;

      if (s3_ff.status != rdpb_pkg::STATUS_OK) begin
         res_in.status = s3_ff.status;
      end else if (out_of_range) begin
         res_in.status = rdpb_pkg::STATUS_BAD_BOX;
      end else begin
         res_in.left   = px_l[EW-1:0];
         res_in.top    = px_t[EW-1:0];
         res_in.right  = px_r[EW-1:0];
         res_in.bottom = px_b[EW-1:0];
         if ((px_r <= px_l) || (px_b <= px_t)) begin
            res_in.status = rdpb_pkg::STATUS_EMPTY_PIXELS;
         end else begin
            res_in.status = rdpb_pkg::STATUS_OK;
         end
      end
   end

   // pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= req_bus.valid;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_free) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (res_free) begin
            res_valid_ff <= s3_valid_ff;
         end
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_ff <= s1_in;
      end
      if (s2_free) begin
         s2_ff <= s2_in;
      end
      if (s3_free) begin
         s3_ff <= s3_in;
      end
      if (res_free) begin
         res_ff <= res_in;
      end
   end

   assign rsp_bus.valid  = res_valid_ff;
   assign rsp_bus.status = res_ff.status;
   assign rsp_bus.left   = res_ff.left;
   assign rsp_bus.top    = res_ff.top;
   assign rsp_bus.right  = res_ff.right;
   assign rsp_bus.bottom = res_ff.bottom;

   // rejected items carry a zero rectangle
   a_reject_zero : assert property (@(posedge clock) disable iff (reset)
      res_valid_ff && (res_ff.status == rdpb_pkg::STATUS_EMPTY_EXTENT
         || res_ff.status == rdpb_pkg::STATUS_NOT_ALIGNED
         || res_ff.status == rdpb_pkg::STATUS_BAD_BOX)
      |-> (res_ff.left == '0) && (res_ff.top == '0)
         && (res_ff.right == '0) && (res_ff.bottom == '0))
      else $error("rejected item with non-zero rectangle");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !s1_valid_ff && !s2_valid_ff && !s3_valid_ff && !res_valid_ff)
      else $error("pipeline holds items after reset");

   // an item in the multiply stage moves on when there is room
   a_stage_move : assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && s3_free |=> s3_valid_ff)
      else $error("item lost between stages");

   a_csr_gain : assert property (@(posedge clock) disable iff (reset)
      csr_write && (csr_bus.index == rdpb_pkg::CSR_X_GAIN)
      |=> x_gain_ff == $signed($past(csr_bus.data)))
      else $error("x gain write not taken");

endmodule
